FILE: design/casb_pkg.sv
package casb_pkg;

	localparam int MAX_DIM_DEF = 4096;
	localparam int QDEPTH      = 4;

	localparam int DIM_W     = 13;
	localparam int POS_W     = 14;
	localparam int CFG_W     = 14;
	localparam int CFG_IDX_W = 3;
	localparam int ADDR_W    = 24;
	localparam int CH_W      = 8;

	localparam logic [DIM_W-1:0] SCREEN_W_RST = 13'd640;
	localparam logic [DIM_W-1:0] SCREEN_H_RST = 13'd480;
	localparam logic [DIM_W-1:0] SPRITE_W_RST = 13'd64;
	localparam logic [DIM_W-1:0] SPRITE_H_RST = 13'd64;

	localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'd255;
	localparam logic [CH_W-1:0] ALPHA_CLEAR  = 8'd0;
	localparam int              BLEND_SHIFT  = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCREEN_W = 3'd0,
		REG_SCREEN_H = 3'd1,
		REG_SPRITE_W = 3'd2,
		REG_SPRITE_H = 3'd3,
		REG_POS_X    = 3'd4,
		REG_POS_Y    = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		PX_SKIP,
		PX_COPY,
		PX_BLEND
	} px_class_t;

	typedef struct packed {
		logic [CH_W-1:0] tex_blue;
		logic [CH_W-1:0] tex_green;
		logic [CH_W-1:0] tex_red;
		logic [CH_W-1:0] tex_alpha;
		logic [CH_W-1:0] dst_blue;
		logic [CH_W-1:0] dst_green;
		logic [CH_W-1:0] dst_red;
		logic [CH_W-1:0] dst_alpha;
	} in_item_t;

	typedef struct packed {
		logic              write_enable;
		logic [ADDR_W-1:0] pixel_address;
		logic [CH_W-1:0]   out_blue;
		logic [CH_W-1:0]   out_green;
		logic [CH_W-1:0]   out_red;
		logic [CH_W-1:0]   out_alpha;
		logic              last_texel;
	} out_item_t;

	typedef struct packed {
		logic [DIM_W-1:0]        screen_width;
		logic [DIM_W-1:0]        screen_height;
		logic [DIM_W-1:0]        sprite_width;
		logic [DIM_W-1:0]        sprite_height;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
	} cfg_t;

	// classified texel waiting for the blend side
	typedef struct packed {
		px_class_t        cls;
		logic             last;
		logic [DIM_W-1:0] col;
		logic [DIM_W-1:0] row;
		in_item_t         pix;
	} q_entry_t;

endpackage

FILE: design/casb_front.sv
module casb_front #(
	parameter int MAX_DIM = casb_pkg::MAX_DIM_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  casb_pkg::in_item_t in_item,
	input  casb_pkg::cfg_t     cfg,
	input  logic               full,
	output logic               push,
	output casb_pkg::q_entry_t push_data
);
	import casb_pkg::*;

	localparam int CW = $clog2(MAX_DIM);
	localparam int XW = ((CW > DIM_W) ? CW : DIM_W) + 2;

	logic [CW-1:0] col_q, row_q;
	logic [CW:0]   col_inc, row_inc;
	logic [XW-1:0] x, y;
	logic          on, end_col, end_row;

	assign in_ready = !full;
	assign push     = in_valid && !full;

	always_comb begin
		col_inc = {1'b0, col_q} + {{CW{1'b0}}, 1'b1};
		row_inc = {1'b0, row_q} + {{CW{1'b0}}, 1'b1};
		x = {{(XW-POS_W){cfg.pos_x[POS_W-1]}}, cfg.pos_x} + {{(XW-CW){1'b0}}, col_q};
		y = {{(XW-POS_W){cfg.pos_y[POS_W-1]}}, cfg.pos_y} + {{(XW-CW){1'b0}}, row_q};
		on = !x[XW-1] && !y[XW-1]
			&& (x < {{(XW-DIM_W){1'b0}}, cfg.screen_width})
			&& (y < {{(XW-DIM_W){1'b0}}, cfg.screen_height});
		// counters left past the end by a resize count as on the last one
		end_col = {{(XW-CW-1){1'b0}}, col_inc} >= {{(XW-DIM_W){1'b0}}, cfg.sprite_width};
		end_row = {{(XW-CW-1){1'b0}}, row_inc} >= {{(XW-DIM_W){1'b0}}, cfg.sprite_height};

		push_data.pix  = in_item;
		push_data.last = end_col && end_row;
		// clipped texels carry zero coordinates so the address comes out as zero
		push_data.col  = on ? x[DIM_W-1:0] : '0;
		push_data.row  = on ? y[DIM_W-1:0] : '0;
		if (!on || in_item.tex_alpha == ALPHA_CLEAR) begin
			push_data.cls = PX_SKIP;
		end else if (in_item.tex_alpha == ALPHA_OPAQUE) begin
			push_data.cls = PX_COPY;
		end else begin
			push_data.cls = PX_BLEND;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (push) begin
			if (!end_col) begin
				col_q <= col_inc[CW-1:0];
			end else begin
				col_q <= '0;
				row_q <= end_row ? '0 : row_inc[CW-1:0];
			end
		end
	end

endmodule

FILE: design/casb_fifo.sv
module casb_fifo #(
	parameter int DEPTH = casb_pkg::QDEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  casb_pkg::q_entry_t push_data,
	output logic               full,
	input  logic               pop,
	output logic               head_valid,
	output casb_pkg::q_entry_t head
);
	import casb_pkg::*;

	localparam int PW = $clog2(DEPTH);

	q_entry_t      mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0]   count_q;

	assign full       = count_q == (PW+1)'(DEPTH);
	assign head_valid = count_q != '0;
	assign head       = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			// pointers wrap at the last entry so depths that are not a power of two work
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + {{(PW-1){1'b0}}, 1'b1};
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + {{(PW-1){1'b0}}, 1'b1};
			end
			if (push && !pop) begin
				count_q <= count_q + {{PW{1'b0}}, 1'b1};
			end else if (pop && !push) begin
				count_q <= count_q - {{PW{1'b0}}, 1'b1};
			end
		end
	end

endmodule

FILE: design/casb_back.sv
module casb_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              head_valid,
	input  casb_pkg::q_entry_t                head,
	output logic                              pop,
	input  logic [casb_pkg::DIM_W-1:0]        screen_width,
	output logic                              out_valid,
	input  logic                              out_ready,
	output casb_pkg::out_item_t               out_item
);
	import casb_pkg::*;

	localparam int PW = 2 * (CH_W + 1);

	// alpha times signed colour difference
	function automatic logic signed [PW-1:0] wdiff(input logic [CH_W-1:0] a,
			input logic [CH_W-1:0] s, input logic [CH_W-1:0] d);
		logic signed [CH_W:0] diff;
		logic signed [CH_W:0] aa;
		diff = $signed({1'b0, s}) - $signed({1'b0, d});
		aa   = $signed({1'b0, a});
		return PW'(aa) * PW'(diff);
	endfunction

	logic                      v_s1, v_s2;
	logic                      ready_s1, ready_s2;
	q_entry_t                  e_s1;
	logic [2*DIM_W-1:0]        row_base_s1;
	logic signed [PW-1:0]      pb_s1, pg_s1, pr_s1;
	out_item_t                 out_s2;

	assign ready_s2  = !v_s2 || out_ready;
	assign ready_s1  = !v_s1 || ready_s2;
	assign pop       = head_valid && ready_s1;
	assign out_valid = v_s2;
	assign out_item  = out_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				v_s1 <= head_valid;
			end
			if (ready_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// multiply stage
	always_ff @(posedge clk) begin
		if (pop) begin
			e_s1        <= head;
			row_base_s1 <= {{DIM_W{1'b0}}, head.row} * {{DIM_W{1'b0}}, screen_width};
			pb_s1       <= wdiff(head.pix.tex_alpha, head.pix.tex_blue, head.pix.dst_blue);
			pg_s1       <= wdiff(head.pix.tex_alpha, head.pix.tex_green, head.pix.dst_green);
			pr_s1       <= wdiff(head.pix.tex_alpha, head.pix.tex_red, head.pix.dst_red);
		end
	end

	// add and select stage, doubles as the output register
	always_ff @(posedge clk) begin
		if (v_s1 && ready_s2) begin
			out_s2.write_enable  <= e_s1.cls != PX_SKIP;
			out_s2.pixel_address <= ADDR_W'(row_base_s1 + {{DIM_W{1'b0}}, e_s1.col});
			out_s2.last_texel    <= e_s1.last;
			case (e_s1.cls)
				PX_COPY: begin
					out_s2.out_blue  <= e_s1.pix.tex_blue;
					out_s2.out_green <= e_s1.pix.tex_green;
					out_s2.out_red   <= e_s1.pix.tex_red;
					out_s2.out_alpha <= e_s1.pix.tex_alpha;
				end
				PX_BLEND: begin
					// only the low byte of the shifted product reaches the sum
					out_s2.out_blue  <= e_s1.pix.dst_blue + pb_s1[BLEND_SHIFT +: CH_W];
					out_s2.out_green <= e_s1.pix.dst_green + pg_s1[BLEND_SHIFT +: CH_W];
					out_s2.out_red   <= e_s1.pix.dst_red + pr_s1[BLEND_SHIFT +: CH_W];
					out_s2.out_alpha <= e_s1.pix.dst_alpha;
				end
				default: begin
					out_s2.out_blue  <= e_s1.pix.dst_blue;
					out_s2.out_green <= e_s1.pix.dst_green;
					out_s2.out_red   <= e_s1.pix.dst_red;
					out_s2.out_alpha <= e_s1.pix.dst_alpha;
				end
			endcase
		end
	end

endmodule

FILE: design/clipped_alpha_sprite_blit_unit.sv
// an accepted texel passes through the queue, the multiply stage and the add and select stage, which drives the output
// throughput: one texel per cycle while the output is ready; the blend and address multipliers are fully pipelined
// a four-entry queue between the clip stage and the blend stages absorbs output stalls
// reset: clears the sprite counters, queue and stage valid bits, and loads the default
// screen and sprite geometry (640 by 480 screen, 64 by 64 sprite at the origin)
module clipped_alpha_sprite_blit_unit #(
	parameter int MAX_DIM     = casb_pkg::MAX_DIM_DEF,
	parameter int QUEUE_DEPTH = casb_pkg::QDEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  casb_pkg::in_item_t                in_item,
	output logic                              out_valid,
	input  logic                              out_ready,
	output casb_pkg::out_item_t               out_item,
	input  logic                              cfg_write,
	input  logic [casb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [casb_pkg::CFG_W-1:0]        cfg_data
);
	import casb_pkg::*;

	localparam int DIM_CAP = (MAX_DIM < (1 << DIM_W)) ? MAX_DIM : (1 << DIM_W) - 1;

	function automatic logic [DIM_W-1:0] dim_sat(input logic [DIM_W-1:0] v,
			input logic one_min);
		logic [DIM_W-1:0] r;
		r = (v > DIM_W'(DIM_CAP)) ? DIM_W'(DIM_CAP) : v;
		if (one_min && r == '0) begin
			r = {{(DIM_W-1){1'b0}}, 1'b1};
		end
		return r;
	endfunction

	cfg_t     cfg_q;
	logic     full, push, pop, head_valid;
	q_entry_t push_data, head;

	// geometry is held already clamped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_width  <= dim_sat(SCREEN_W_RST, 1'b0);
			cfg_q.screen_height <= dim_sat(SCREEN_H_RST, 1'b0);
			cfg_q.sprite_width  <= dim_sat(SPRITE_W_RST, 1'b1);
			cfg_q.sprite_height <= dim_sat(SPRITE_H_RST, 1'b1);
			cfg_q.pos_x         <= '0;
			cfg_q.pos_y         <= '0;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SCREEN_W: cfg_q.screen_width  <= dim_sat(cfg_data[DIM_W-1:0], 1'b0);
				REG_SCREEN_H: cfg_q.screen_height <= dim_sat(cfg_data[DIM_W-1:0], 1'b0);
				REG_SPRITE_W: cfg_q.sprite_width  <= dim_sat(cfg_data[DIM_W-1:0], 1'b1);
				REG_SPRITE_H: cfg_q.sprite_height <= dim_sat(cfg_data[DIM_W-1:0], 1'b1);
				REG_POS_X:    cfg_q.pos_x         <= $signed(cfg_data[POS_W-1:0]);
				REG_POS_Y:    cfg_q.pos_y         <= $signed(cfg_data[POS_W-1:0]);
				default: begin
				end
			endcase
		end
	end

	casb_front #(
		.MAX_DIM(MAX_DIM)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.cfg      (cfg_q),
		.full     (full),
		.push     (push),
		.push_data(push_data)
	);

	casb_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.head_valid(head_valid),
		.head      (head)
	);

	casb_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head        (head),
		.pop         (pop),
		.screen_width(cfg_q.screen_width),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_item    (out_item)
	);

endmodule

FILE: design/casb_checker.sv
module casb_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input casb_pkg::out_item_t out_item
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result changed or dropped while stalled");

	// nothing comes out straight after reset
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !out_valid)
		else $error("result shown right after reset");

	// the queue only fills by taking a transaction
	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(in_valid && in_ready))
		else $error("input ready dropped without a transaction");

	// a shown result never carries unknown bits
	a_out_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !$isunknown(out_item))
		else $error("result shown with unknown bits");

endmodule

bind clipped_alpha_sprite_blit_unit casb_checker u_casb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_item (out_item)
);
